@@ rtl/mck_pkg.sv @@
// ----------------------------------------------------------------------------
// mck_pkg
// Types, register indexes and the keying table of the Morse character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 16;
   localparam int DUR_W      = 18;
   localparam int ELEM_MAX   = 5;
   localparam int ELEM_CNT_W = 3;
   localparam int ELEM_IDX_W = 3;
   localparam int SEG_W      = 4;
   localparam int SLOT_W     = 6;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DOT_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DASH_LENGTH = 2'd1;

   localparam logic [LEN_W-1:0] DOT_LENGTH_RESET  = 16'd100;
   localparam logic [LEN_W-1:0] DASH_LENGTH_RESET = 16'd400;

   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [SLOT_W-1:0] DIGIT_SLOT_BASE = 6'd26;

   // pattern bit i is element i, first element in bit 0; 1 = dash
   typedef struct packed {
      logic [ELEM_CNT_W-1:0] len;
      logic [ELEM_MAX-1:0]   pattern;
   } code_type;

   function automatic code_type code_lookup(input logic [SLOT_W-1:0] slot);
      code_type c;
      unique case (slot)
         6'd0:    c = '{3'd2, 5'b00010};
         6'd1:    c = '{3'd4, 5'b00001};
         6'd2:    c = '{3'd4, 5'b00101};
         6'd3:    c = '{3'd3, 5'b00001};
         6'd4:    c = '{3'd1, 5'b00000};
         6'd5:    c = '{3'd4, 5'b00100};
         6'd6:    c = '{3'd3, 5'b00011};
         6'd7:    c = '{3'd4, 5'b00000};
         6'd8:    c = '{3'd2, 5'b00000};
         6'd9:    c = '{3'd4, 5'b01110};
         6'd10:   c = '{3'd3, 5'b00101};
         6'd11:   c = '{3'd4, 5'b00010};
         6'd12:   c = '{3'd2, 5'b00011};
         6'd13:   c = '{3'd2, 5'b00001};
         6'd14:   c = '{3'd3, 5'b00111};
         6'd15:   c = '{3'd4, 5'b00110};
         6'd16:   c = '{3'd4, 5'b01011};
         6'd17:   c = '{3'd3, 5'b00010};
         6'd18:   c = '{3'd3, 5'b00000};
         6'd19:   c = '{3'd1, 5'b00001};
         6'd20:   c = '{3'd3, 5'b00100};
         6'd21:   c = '{3'd4, 5'b01000};
         6'd22:   c = '{3'd3, 5'b00110};
         6'd23:   c = '{3'd4, 5'b01001};
         6'd24:   c = '{3'd4, 5'b01101};
         6'd25:   c = '{3'd4, 5'b00011};
         6'd26:   c = '{3'd5, 5'b11111};
         6'd27:   c = '{3'd5, 5'b11110};
         6'd28:   c = '{3'd5, 5'b11100};
         6'd29:   c = '{3'd5, 5'b11000};
         6'd30:   c = '{3'd5, 5'b10000};
         6'd31:   c = '{3'd5, 5'b00000};
         6'd32:   c = '{3'd5, 5'b00001};
         6'd33:   c = '{3'd5, 5'b00011};
         6'd34:   c = '{3'd5, 5'b00111};
         6'd35:   c = '{3'd5, 5'b01111};
         default: c = '{3'd0, 5'b00000};
      endcase
      return c;
   endfunction

endpackage

@@ rtl/morse_character_keyer.sv @@
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns one ASCII character into its Morse keying as tone/silence segments.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one word per character, ASCII code in req_tdata[7:0].
//   rsp_*  : one word per segment; rsp_tuser[0] is 1 for tone, 0 for silence,
//            rsp_tdata[17:0] is the segment length in ms, rsp_tlast marks
//            the closing character gap.
//   csr_*  : register writes, index 0 dot length, index 1 dash length.
//            Writes are always taken (csr_ready high); other indexes are
//            dropped.
// Each keyed character ('a'-'z', '0'-'9') of n elements gives 2n+1 segments
// (3 to 11), one per cycle from the single segment sequencer while the output
// register can load (empty or rsp_tready high). Any other code is taken and dropped.
// The first segment passes through the sequencer and then the output register,
// and the next character is taken in the cycle its predecessor's gap segment is
// loaded into the output register.
// Reset empties the sequencer and the output register and sets the dot
// length to 100 ms and the dash length to 400 ms.
// While rsp_tready is low the output register holds its segment and the
// sequencer waits.
// ----------------------------------------------------------------------------
module morse_character_keyer
   import mck_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] character
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [17:0] duration_ms, [23:18] zero
   output logic [0:0]           rsp_tuser,   // [0] tone_on
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data
);

   logic [LEN_W-1:0]      dot_len_ff, dot_len_in;
   logic [LEN_W-1:0]      dash_len_ff, dash_len_in;

   logic                  job_valid_ff, job_valid_in;
   logic [ELEM_CNT_W-1:0] job_len_ff, job_len_in;
   logic [ELEM_MAX-1:0]   job_code_ff, job_code_in;
   logic [SEG_W-1:0]      job_seg_ff, job_seg_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_tone_ff, out_tone_in;
   logic [DUR_W-1:0]      out_dur_ff, out_dur_in;
   logic                  out_last_ff, out_last_in;

   logic                  req_fire;
   logic                  out_load;
   logic                  seg_gap;
   logic                  seg_final;
   logic                  keyed;
   logic [SLOT_W-1:0]     slot;
   code_type              code;
   logic [ELEM_IDX_W-1:0] elem_idx;
   logic [DUR_W-1:0]      gap_dur;

   assign csr_ready = 1'b1;

   always_comb begin
      dot_len_in  = dot_len_ff;
      dash_len_in = dash_len_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_DOT_LENGTH) begin
            dot_len_in = csr_data;
         end
         if (csr_index == REG_DASH_LENGTH) begin
            dash_len_in = csr_data;
         end
      end
   end

   // decode the character into its element count and pattern
   always_comb begin
      keyed = 1'b0;
      slot  = '0;
      if (req_tdata >= CHAR_LOWER_A && req_tdata <= CHAR_LOWER_Z) begin
         keyed = 1'b1;
         slot  = SLOT_W'(req_tdata - CHAR_LOWER_A);
      end else if (req_tdata >= CHAR_DIGIT_0 && req_tdata <= CHAR_DIGIT_9) begin
         keyed = 1'b1;
         slot  = SLOT_W'(req_tdata - CHAR_DIGIT_0) + DIGIT_SLOT_BASE;
      end
      code = code_lookup(slot);
   end

   assign out_load  = !out_valid_ff || rsp_tready;
   assign seg_gap   = (job_seg_ff == {job_len_ff, 1'b0});
   assign seg_final = job_valid_ff && seg_gap;
   assign req_tready = !job_valid_ff || (seg_final && out_load);
   assign req_fire  = req_tvalid && req_tready;
   assign elem_idx  = job_seg_ff[SEG_W-1:1];
   assign gap_dur   = {2'b00, dash_len_ff} + {1'b0, dash_len_ff, 1'b0};

   // advance the sequencer one segment per loaded output word
   always_comb begin
      job_valid_in = job_valid_ff;
      job_len_in   = job_len_ff;
      job_code_in  = job_code_ff;
      job_seg_in   = job_seg_ff;
      if (job_valid_ff && out_load) begin
         job_seg_in = job_seg_ff + SEG_W'(1);
         if (seg_gap) begin
            job_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         job_valid_in = keyed;
         job_len_in   = code.len;
         job_code_in  = code.pattern;
         job_seg_in   = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_tone_in  = out_tone_ff;
      out_dur_in   = out_dur_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = job_valid_ff;
         if (seg_gap) begin
            out_tone_in = 1'b0;
            out_dur_in  = gap_dur;
            out_last_in = 1'b1;
         end else if (job_seg_ff[0]) begin
            out_tone_in = 1'b0;
            out_dur_in  = {2'b00, dash_len_ff};
            out_last_in = 1'b0;
         end else begin
            out_tone_in = 1'b1;
            out_dur_in  = job_code_ff[elem_idx] ? {2'b00, dash_len_ff}
                                                : {2'b00, dot_len_ff};
            out_last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_len_ff   <= DOT_LENGTH_RESET;
         dash_len_ff  <= DASH_LENGTH_RESET;
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dot_len_ff   <= dot_len_in;
         dash_len_ff  <= dash_len_in;
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_len_ff  <= job_len_in;
      job_code_ff <= job_code_in;
      job_seg_ff  <= job_seg_in;
      out_tone_ff <= out_tone_in;
      out_dur_ff  <= out_dur_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {{(24-DUR_W){1'b0}}, out_dur_ff};
   assign rsp_tuser[0] = out_tone_ff;
   assign rsp_tlast    = out_last_ff;

   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_seg_ff <= {job_len_ff, 1'b0}
                        && job_len_ff != '0
                        && job_len_ff <= ELEM_CNT_W'(ELEM_MAX)))
      else $error("segment index beyond character gap");

   a_gap_is_silence: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser[0])
      else $error("character gap carries tone");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> job_valid_ff && !(seg_final && out_load))
      else $error("request stalled without pending segments");

   a_seg_advance: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && out_load && !seg_gap |=> job_valid_ff
                                             && job_seg_ff == $past(job_seg_ff) + SEG_W'(1))
      else $error("sequencer skipped or repeated a segment");

   a_reset_lengths: assert property (@(posedge clock)
      $past(reset) |-> dot_len_ff == DOT_LENGTH_RESET && dash_len_ff == DASH_LENGTH_RESET)
      else $error("length registers not at reset value");

endmodule
